FILE: src/cwes_pkg.sv
// shared types and constants for the digital clock with knob-driven set mode
package cwes_pkg;

   localparam int unsigned CSR_WIDTH = 16;
   localparam int unsigned CSR_INDEX_WIDTH = 2;

   typedef enum logic [1:0] {
      MODE_RUN  = 2'd0,
      MODE_SEC  = 2'd1,
      MODE_MIN  = 2'd2,
      MODE_HOUR = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      REQ_NONE  = 2'd0,
      REQ_CCW   = 2'd1,
      REQ_CW    = 2'd2,
      REQ_PRESS = 2'd3
   } req_code_type;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TICKS_PER_SECOND = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BLINK_SHOW_AT    = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BLINK_PERIOD     = 2'd2;

   localparam logic [CSR_WIDTH-1:0] TICKS_PER_SECOND_RESET = 16'd20;
   localparam logic [CSR_WIDTH-1:0] BLINK_SHOW_AT_RESET    = 16'd20000;
   localparam logic [CSR_WIDTH-1:0] BLINK_PERIOD_RESET     = 16'd60000;

   localparam logic [5:0] SEC_TOP  = 6'd59;
   localparam logic [5:0] MIN_TOP  = 6'd59;
   localparam logic [4:0] HOUR_TOP = 5'd23;

endpackage

FILE: src/cwes_if.sv
// valid/ready channel interfaces for knob events and clock results
interface cwes_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   logic       long_press;

   modport source (output valid, output req_type, output long_press, input ready);
   modport sink (input valid, input req_type, input long_press, output ready);
endinterface

interface cwes_rsp_if;
   logic       valid;
   logic       ready;
   logic [4:0] hours;
   logic [5:0] minutes;
   logic [5:0] seconds;
   logic [1:0] mode;
   logic       field_visible;

   modport source (output valid, output hours, output minutes, output seconds,
                   output mode, output field_visible, input ready);
   modport sink (input valid, input hours, input minutes, input seconds,
                 input mode, input field_visible, output ready);
endinterface

FILE: src/clock_with_encoder_setting.sv
// Digital hh:mm:ss clock with knob-driven set mode. Each accepted word on req_chan is one loop
// pass carrying a knob event and a long-press flag; it produces exactly one result word on
// rsp_chan with the time, the mode and the visibility of the selected field. The whole update
// is one pass of logic from the state registers into the result register, so a word is taken
// every cycle as long as the result register is empty or being drained in the same cycle; the
// result register is the only stage between the two sides. Registers on the csr_ port (0 ticks
// per second, 1 blink show point, 2 blink period) are to be written by the user only while idle;
// the block itself does not enforce it.
module clock_with_encoder_setting
   import cwes_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   cwes_req_if.sink                   req_chan,
   cwes_rsp_if.source                 rsp_chan,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_WIDTH-1:0]       csr_wdata
);

   logic [CSR_WIDTH-1:0] ticks_per_second_ff;
   logic [CSR_WIDTH-1:0] blink_show_at_ff;
   logic [CSR_WIDTH-1:0] blink_period_ff;

   logic [4:0]  hour_ff, hour_in;
   logic [5:0]  minute_ff, minute_in;
   logic [5:0]  second_ff, second_in;
   mode_type    mode_ff, mode_in;
   logic [15:0] pass_count_ff, pass_count_in;
   logic [15:0] blink_phase_ff, blink_phase_in;
   logic        visible_ff, visible_in;

   logic        rsp_valid_ff;
   logic [4:0]  rsp_hours_ff;
   logic [5:0]  rsp_minutes_ff;
   logic [5:0]  rsp_seconds_ff;
   mode_type    rsp_mode_ff;
   logic        rsp_visible_ff;

   logic        accept;
   logic [15:0] pass_inc;
   logic [15:0] blink_base;
   logic        sec_carry;
   logic        min_carry;
   req_code_type req_code;

   assign req_code = req_code_type'(req_chan.req_type);
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept = req_chan.valid && req_chan.ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_per_second_ff <= TICKS_PER_SECOND_RESET;
         blink_show_at_ff    <= BLINK_SHOW_AT_RESET;
         blink_period_ff     <= BLINK_PERIOD_RESET;
      end else if (csr_we) begin
         if (csr_index == CSR_TICKS_PER_SECOND) ticks_per_second_ff <= csr_wdata;
         if (csr_index == CSR_BLINK_SHOW_AT) blink_show_at_ff <= csr_wdata;
         if (csr_index == CSR_BLINK_PERIOD) blink_period_ff <= csr_wdata;
      end
   end

   assign pass_inc  = pass_count_ff + 16'd1;
   assign sec_carry = (second_ff >= SEC_TOP);
   assign min_carry = (minute_ff >= MIN_TOP);

   always_comb begin
      hour_in        = hour_ff;
      minute_in      = minute_ff;
      second_in      = second_ff;
      mode_in        = mode_ff;
      pass_count_in  = pass_count_ff;
      blink_phase_in = blink_phase_ff;
      visible_in     = visible_ff;
      blink_base     = blink_phase_ff;
      if (mode_ff == MODE_RUN) begin
         // prescaler, then seconds with carry into minutes and hours
         if (pass_inc >= ticks_per_second_ff) begin
            pass_count_in = '0;
            if (sec_carry) begin
               second_in = '0;
               if (min_carry) begin
                  minute_in = '0;
                  hour_in   = (hour_ff >= HOUR_TOP) ? 5'd0 : hour_ff + 5'd1;
               end else begin
                  minute_in = minute_ff + 6'd1;
               end
            end else begin
               second_in = second_ff + 6'd1;
            end
         end else begin
            pass_count_in = pass_inc;
         end
         if (req_code == REQ_PRESS) begin
            mode_in    = MODE_SEC;
            visible_in = 1'b1;
         end
      end else begin
         // blink: blanking wins at count one
         priority if (blink_phase_ff == 16'd1) begin
            visible_in = 1'b0;
         end else if (blink_phase_ff == blink_show_at_ff) begin
            visible_in = 1'b1;
         end else if (blink_phase_ff == blink_period_ff) begin
            blink_base = '0;
         end else begin
            blink_base = blink_phase_ff;
         end
         blink_phase_in = blink_base + 16'd1;

         priority if (req_chan.long_press) begin
            mode_in = MODE_RUN;
         end else if (req_code == REQ_CW) begin
            unique case (mode_ff)
               MODE_SEC:  second_in = (second_ff >= SEC_TOP) ? 6'd0 : second_ff + 6'd1;
               MODE_MIN:  minute_in = (minute_ff >= MIN_TOP) ? 6'd0 : minute_ff + 6'd1;
               default:   hour_in = (hour_ff >= HOUR_TOP) ? 5'd0 : hour_ff + 5'd1;
            endcase
            visible_in = 1'b1;
         end else if (req_code == REQ_CCW) begin
            unique case (mode_ff)
               MODE_SEC:  second_in = (second_ff == 6'd0 || second_ff > SEC_TOP) ?
                                      SEC_TOP : second_ff - 6'd1;
               MODE_MIN:  minute_in = (minute_ff == 6'd0 || minute_ff > MIN_TOP) ?
                                      MIN_TOP : minute_ff - 6'd1;
               default:   hour_in = (hour_ff == 5'd0 || hour_ff > HOUR_TOP) ?
                                    HOUR_TOP : hour_ff - 5'd1;
            endcase
            visible_in = 1'b1;
         end else if (req_code == REQ_PRESS) begin
            unique case (mode_ff)
               MODE_SEC:  mode_in = MODE_MIN;
               MODE_MIN:  mode_in = MODE_HOUR;
               default:   mode_in = MODE_RUN;
            endcase
            visible_in = 1'b1;
         end else begin
            mode_in = mode_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hour_ff        <= '0;
         minute_ff      <= '0;
         second_ff      <= '0;
         mode_ff        <= MODE_RUN;
         pass_count_ff  <= '0;
         blink_phase_ff <= '0;
         visible_ff     <= 1'b1;
      end else if (accept) begin
         hour_ff        <= hour_in;
         minute_ff      <= minute_in;
         second_ff      <= second_in;
         mode_ff        <= mode_in;
         pass_count_ff  <= pass_count_in;
         blink_phase_ff <= blink_phase_in;
         visible_ff     <= visible_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_hours_ff   <= hour_in;
         rsp_minutes_ff <= minute_in;
         rsp_seconds_ff <= second_in;
         rsp_mode_ff    <= mode_in;
         rsp_visible_ff <= (mode_in == MODE_RUN) ? 1'b1 : visible_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.hours         = rsp_hours_ff;
   assign rsp_chan.minutes       = rsp_minutes_ff;
   assign rsp_chan.seconds       = rsp_seconds_ff;
   assign rsp_chan.mode          = rsp_mode_ff;
   assign rsp_chan.field_visible = rsp_visible_ff;

   a_time_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_hours_ff <= HOUR_TOP && rsp_minutes_ff <= MIN_TOP &&
                        rsp_seconds_ff <= SEC_TOP))
      else $error("result time out of range");

   a_run_visible: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_mode_ff == MODE_RUN) |-> rsp_visible_ff)
      else $error("field blanked in run mode");

   a_run_stays: assert property (@(posedge clock) disable iff (reset)
      (accept && mode_ff == MODE_RUN && req_code != REQ_PRESS) |=> mode_ff == MODE_RUN)
      else $error("left run mode without a press");

   a_blink_holds: assert property (@(posedge clock) disable iff (reset)
      (accept && mode_ff == MODE_RUN) |=> blink_phase_ff == $past(blink_phase_ff))
      else $error("blink phase moved in run mode");

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for the digital clock with knob-driven set mode
module testbench;
   import cwes_pkg::*;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      logic [4:0] hours;
      logic [5:0] minutes;
      logic [5:0] seconds;
      logic [1:0] mode;
      logic       field_visible;
   } clock_word_type;

   class clock_scoreboard;
      logic [15:0] ticks_per_second = TICKS_PER_SECOND_RESET;
      logic [15:0] blink_show_at    = BLINK_SHOW_AT_RESET;
      logic [15:0] blink_period     = BLINK_PERIOD_RESET;
      logic [4:0]  hours            = '0;
      logic [5:0]  minutes          = '0;
      logic [5:0]  seconds          = '0;
      mode_type    clock_mode       = MODE_RUN;
      logic [15:0] pass_count       = '0;
      logic [15:0] blink_phase      = '0;
      logic        visible          = 1'b1;
      clock_word_type expected_q[$];
      int unsigned mismatches       = 0;
      int unsigned words_seen       = 0;

      function void set_register(logic [CSR_INDEX_WIDTH-1:0] index, logic [CSR_WIDTH-1:0] data);
         case (index)
            CSR_TICKS_PER_SECOND: ticks_per_second = data;
            CSR_BLINK_SHOW_AT:    blink_show_at = data;
            CSR_BLINK_PERIOD:     blink_period = data;
            default: ;
         endcase
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      function logic [5:0] nudge(logic [5:0] v, logic [5:0] top, bit up);
         if (up)
            return (v >= top) ? 6'd0 : v + 6'd1;
         return (v == 6'd0 || v > top) ? top : v - 6'd1;
      endfunction

      function void tick_second();
         seconds = seconds + 6'd1;
         if (seconds >= 6'd60) begin
            seconds = '0;
            minutes = minutes + 6'd1;
            if (minutes >= 6'd60) begin
               minutes = '0;
               hours = hours + 5'd1;
               if (hours >= 5'd24)
                  hours = '0;
            end
         end
      endfunction

      function void note_word(req_code_type kind, logic long_press);
         clock_word_type w;
         bit up;
         up = (kind == REQ_CW);
         if (clock_mode == MODE_RUN) begin
            pass_count = pass_count + 16'd1;
            if (pass_count >= ticks_per_second) begin
               pass_count = '0;
               tick_second();
            end
            if (kind == REQ_PRESS) begin
               clock_mode = MODE_SEC;
               visible = 1'b1;
            end
         end else begin
            // blanking wins at count one, then the show point, then the restart
            if (blink_phase == 16'd1)
               visible = 1'b0;
            else if (blink_phase == blink_show_at)
               visible = 1'b1;
            else if (blink_phase == blink_period)
               blink_phase = '0;
            blink_phase = blink_phase + 16'd1;
            if (long_press) begin
               clock_mode = MODE_RUN;
            end else if (kind == REQ_CW || kind == REQ_CCW) begin
               case (clock_mode)
                  MODE_SEC: seconds = nudge(seconds, SEC_TOP, up);
                  MODE_MIN: minutes = nudge(minutes, MIN_TOP, up);
                  default:  hours = 5'(nudge({1'b0, hours}, {1'b0, HOUR_TOP}, up));
               endcase
               visible = 1'b1;
            end else if (kind == REQ_PRESS) begin
               case (clock_mode)
                  MODE_SEC: clock_mode = MODE_MIN;
                  MODE_MIN: clock_mode = MODE_HOUR;
                  default:  clock_mode = MODE_RUN;
               endcase
               visible = 1'b1;
            end
         end
         w.hours = hours;
         w.minutes = minutes;
         w.seconds = seconds;
         w.mode = clock_mode;
         w.field_visible = (clock_mode == MODE_RUN) ? 1'b1 : visible;
         expected_q.push_back(w);
      endfunction

      task report(string msg);
         mismatches++;
         if (mismatches <= 40)
            $display("mismatch: %s", msg);
      endtask

      task check_word(clock_word_type got);
         clock_word_type want;
         words_seen++;
         if (expected_q.size() == 0) begin
            report($sformatf("word %0d arrived with nothing expected", words_seen));
            return;
         end
         want = expected_q.pop_front();
         if (got.hours !== want.hours)
            report($sformatf("word %0d hours %0d, expected %0d", words_seen,
                             got.hours, want.hours));
         if (got.minutes !== want.minutes)
            report($sformatf("word %0d minutes %0d, expected %0d", words_seen,
                             got.minutes, want.minutes));
         if (got.seconds !== want.seconds)
            report($sformatf("word %0d seconds %0d, expected %0d", words_seen,
                             got.seconds, want.seconds));
         if (got.mode !== want.mode)
            report($sformatf("word %0d mode %0d, expected %0d", words_seen,
                             got.mode, want.mode));
         if (got.field_visible !== want.field_visible)
            report($sformatf("word %0d field_visible %0b, expected %0b", words_seen,
                             got.field_visible, want.field_visible));
      endtask
   endclass

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       csr_we;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_WIDTH-1:0]       csr_wdata;
   int unsigned                gap_pct;
   int unsigned                stall_pct;
   int unsigned                stall_left = 0;
   clock_scoreboard            sb;

   cwes_req_if req_if();
   cwes_rsp_if rsp_if();

   clock_with_encoder_setting dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   // result side: random stalls, each a burst of ready held low
   always @(negedge clock) begin
      if (stall_left != 0) begin
         stall_left--;
         rsp_if.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < stall_pct) begin
         stall_left = $urandom_range(0, 11);
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // input noted before result checked, so a same-edge pair stays in order
   always @(posedge clock) begin : watch
      clock_word_type seen;
      if (reset === 1'b0) begin
         if (req_if.valid === 1'b1 && req_if.ready === 1'b1)
            sb.note_word(req_code_type'(req_if.req_type), req_if.long_press);
         if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            seen.hours = rsp_if.hours;
            seen.minutes = rsp_if.minutes;
            seen.seconds = rsp_if.seconds;
            seen.mode = rsp_if.mode;
            seen.field_visible = rsp_if.field_visible;
            sb.check_word(seen);
         end
      end
   end

   task automatic send_word(req_code_type kind, logic long_press);
      req_if.valid <= 1'b1;
      req_if.req_type <= kind;
      req_if.long_press <= long_press;
      @(posedge clock);
      while (req_if.ready !== 1'b1)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic idle_cycles(int unsigned n);
      // junk on the payload while valid is low
      req_if.valid <= 1'b0;
      req_if.req_type <= req_code_type'($urandom_range(0, 3));
      req_if.long_press <= 1'($urandom_range(0, 1));
      repeat (n) @(negedge clock);
   endtask

   task automatic maybe_gap();
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
         idle_cycles($urandom_range(1, 12));
   endtask

   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (sb.pending() != 0)
         @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic apply_settings(logic [15:0] ticks, logic [15:0] show_at, logic [15:0] period);
      logic [CSR_WIDTH-1:0] vals[4];
      vals[CSR_TICKS_PER_SECOND] = ticks;
      vals[CSR_BLINK_SHOW_AT] = show_at;
      vals[CSR_BLINK_PERIOD] = period;
      vals[CSR_SPARE] = CSR_WIDTH'($urandom);
      for (int i = 0; i < 4; i++) begin
         csr_we <= 1'b1;
         csr_index <= CSR_INDEX_WIDTH'(i);
         csr_wdata <= vals[i];
         sb.set_register(CSR_INDEX_WIDTH'(i), vals[i]);
         @(negedge clock);
      end
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // mostly sensible knob use for the current mode, the rest anything at all
   task automatic random_word();
      req_code_type kind;
      logic         lp;
      int unsigned  pick;
      pick = $urandom_range(0, 99);
      lp = 1'b0;
      if (pick < 25) begin
         kind = req_code_type'($urandom_range(0, 3));
         lp = 1'($urandom_range(0, 1));
      end else if (sb.clock_mode == MODE_RUN) begin
         kind = ($urandom_range(0, 99) < 15) ? REQ_PRESS : REQ_NONE;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 35)
            kind = REQ_CW;
         else if (pick < 70)
            kind = REQ_CCW;
         else if (pick < 85)
            kind = REQ_PRESS;
         else
            kind = REQ_NONE;
         lp = ($urandom_range(0, 99) < 6);
      end
      send_word(kind, lp);
   endtask

   task automatic run_phase(logic [15:0] ticks, logic [15:0] show_at, logic [15:0] period,
                            int unsigned gap, int unsigned stall, int unsigned words);
      int unsigned hold_at;
      hold_at = $urandom_range(words / 4, 3 * words / 4);
      wait_idle();
      apply_settings(ticks, show_at, period);
      gap_pct = gap;
      stall_pct = stall;
      for (int unsigned n = 0; n < words; n++) begin
         if (n == hold_at)
            wait_idle();
         else
            maybe_gap();
         random_word();
      end
      wait_idle();
   endtask

   initial begin
      sb = new();
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.req_type = REQ_NONE;
      req_if.long_press = 1'b0;
      gap_pct = 0;
      stall_pct = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // every field wrapped both ways, ending at 23:59:59
      send_word(REQ_PRESS, 1'b0);
      for (int f = 0; f < 3; f++) begin
         send_word(REQ_CCW, 1'b0);
         send_word(REQ_CW, 1'b0);
         send_word(REQ_CCW, 1'b0);
         if (f < 2)
            send_word(REQ_PRESS, 1'b0);
      end
      send_word(REQ_CW, 1'b1);   // long press beats the rotation
      wait_idle();
      // zero prescale, show point on the blanking count
      apply_settings(16'd0, 16'd1, 16'd3);
      send_word(REQ_NONE, 1'b0); // carry through midnight
      send_word(REQ_CW, 1'b1);
      send_word(REQ_PRESS, 1'b1);
      send_word(REQ_PRESS, 1'b1);
      repeat (4) send_word(REQ_PRESS, 1'b0);
      wait_idle();

      // period 1 never matches as blanking wins there
      apply_settings(16'($urandom_range(1, 40)), 16'd0, 16'd1);
      send_word(REQ_PRESS, 1'b0);
      repeat (200)
         send_word(($urandom_range(0, 199) == 0) ? REQ_CW : REQ_NONE, 1'b0);
      send_word(REQ_NONE, 1'b1);
      wait_idle();

      run_phase(16'd1, 16'd3, 16'd6, 30, 30, 230);
      run_phase(16'd0, 16'hFFFF, 16'd0, 20, 40, 230);
      run_phase(16'hFFFF, 16'd1, 16'd2, 40, 20, 230);
      run_phase(16'($urandom_range(1, 5)), 16'($urandom_range(1, 20)),
                16'($urandom_range(2, 30)), 25, 25, 230);
      run_phase(16'($urandom), 16'($urandom_range(1, 40)), 16'hFFFF, 30, 30, 230);
      run_phase(16'($urandom), 16'($urandom), 16'($urandom), 30, 30, 230);
      // show point past the period, and no idling on either side
      run_phase(16'd2, 16'd7, 16'd4, 0, 0, 230);

      if (sb.mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #20000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

FILE: files.f
src/cwes_pkg.sv
src/cwes_if.sv
src/clock_with_encoder_setting.sv
test/testbench.sv
